FILE: rtl/core/ffhc_pkg.sv
// shared types, constants and hash helpers for the form field hash classifier
`default_nettype none

package ffhc_pkg;

    localparam int MAX_BODY = 65535;

    localparam int HASH_W   = 32;
    localparam int OFFSET_W = 16;
    localparam int START_W  = 17;
    localparam int CLASS_W  = 2;
    localparam int CFG_IDX_W = 2;

    // byte offset saturates here on an overlong body
    localparam logic [OFFSET_W-1:0] OFFSET_LAST = OFFSET_W'(MAX_BODY - 1);

    localparam logic [7:0] CH_EQ  = 8'h3D;
    localparam logic [7:0] CH_AMP = 8'h26;

    localparam logic [CLASS_W-1:0] CLASS_INTERFACE = 2'd0;
    localparam logic [CLASS_W-1:0] CLASS_METHOD    = 2'd1;
    localparam logic [CLASS_W-1:0] CLASS_TYPES     = 2'd2;
    localparam logic [CLASS_W-1:0] CLASS_PARAM     = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_INTERFACE_KEY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_METHOD_KEY    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TYPES_KEY     = 2'd2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [HASH_W-1:0] iface;
        logic [HASH_W-1:0] method;
        logic [HASH_W-1:0] types;
    } keys_t;

    typedef struct packed {
        logic [CLASS_W-1:0]  cls;
        logic [START_W-1:0]  vs;
        logic [OFFSET_W-1:0] ve;
    } result_t;

    // one queue word: the results caused by one body byte
    typedef struct packed {
        result_t first;
        result_t second;
        logic    two;
    } entry_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    // hash*131 + signed byte, as shift-adds
    function automatic logic [HASH_W-1:0] hash_step(input logic [HASH_W-1:0] h,
                                                    input logic [7:0] b);
        logic [HASH_W-1:0] sb;
        sb = {{(HASH_W - 8){b[7]}}, b};
        return (h << 7) + (h << 1) + h + sb;
    endfunction

    function automatic logic [CLASS_W-1:0] classify(input logic [HASH_W-1:0] h,
                                                   input keys_t k);
        logic [CLASS_W-1:0] c;
        priority if (h == k.iface)  c = CLASS_INTERFACE;
        else if (h == k.method)     c = CLASS_METHOD;
        else if (h == k.types)      c = CLASS_TYPES;
        else                        c = CLASS_PARAM;
        return c;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/form_field_hash_classifier.sv
// a body byte's results go into the queue, and from there its first result into the output register
// the sink takes each result from the output register, which holds it while the sink stalls
// one byte per cycle in, one result per cycle out, each unless stalled; a final '&' gives two results
// a four-word queue between parser and output lets input run while the output stalls
// the byte side stalls only when that queue is full
// reset clears key registers, parser state, the queue pointers and count, and the output valid flag
`default_nettype none

module form_field_hash_classifier (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [ffhc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ffhc_pkg::HASH_W-1:0]     cfg_data,
    input  wire logic                            byte_valid,
    output logic                                 byte_stall,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            body_end,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic [ffhc_pkg::CLASS_W-1:0]         field_class,
    output logic [ffhc_pkg::START_W-1:0]         value_start,
    output logic [ffhc_pkg::OFFSET_W-1:0]        value_end,
    output logic                                 run_last
);
    import ffhc_pkg::*;

    entry_t        push_entry;
    entry_t        head;
    queue_status_t status;
    logic          push;
    logic          pop;
    logic          take;

    assign byte_stall = status.full;
    assign take       = byte_valid && !status.full;

    ffhc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .take       (take),
        .data_byte  (data_byte),
        .body_end   (body_end),
        .push       (push),
        .push_entry (push_entry)
    );

    ffhc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .status     (status)
    );

    ffhc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .status       (status),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .field_class  (field_class),
        .value_start  (value_start),
        .value_end    (value_end),
        .run_last     (run_last)
    );

endmodule

`default_nettype wire

FILE: rtl/core/ffhc_front.sv
// front end: key registers, name hashing, field classing and span tracking
`default_nettype none

module ffhc_front (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_write,
    input  wire logic [ffhc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ffhc_pkg::HASH_W-1:0]     cfg_data,
    input  wire logic                            take,
    input  wire logic [7:0]                      data_byte,
    input  wire logic                            body_end,
    output logic                                 push,
    output ffhc_pkg::entry_t                     push_entry
);
    import ffhc_pkg::*;

    keys_t               keys_reg, keys_next;
    logic                in_value_reg, in_value_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [CLASS_W-1:0]  class_reg, class_next;
    logic [START_W-1:0]  start_reg, start_next;
    logic [OFFSET_W-1:0] offset_reg, offset_next;

    logic [START_W-1:0]  len17;
    logic [OFFSET_W-1:0] len16;
    logic [HASH_W-1:0]   hash_new;
    logic [CLASS_W-1:0]  class_cur;
    logic [CLASS_W-1:0]  class_new;
    logic [CLASS_W-1:0]  class_zero;
    logic                has_result;

    always_comb
    begin
        keys_next = keys_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_INTERFACE_KEY: keys_next.iface  = cfg_data;
                REG_METHOD_KEY:    keys_next.method = cfg_data;
                REG_TYPES_KEY:     keys_next.types  = cfg_data;
                default:           keys_next = keys_reg;
            endcase
        end
    end

    assign len17      = {1'b0, offset_reg} + START_W'(1);
    assign len16      = offset_reg + OFFSET_W'(1);
    assign hash_new   = hash_step(hash_reg, data_byte);
    assign class_cur  = classify(hash_reg, keys_reg);
    assign class_new  = classify(hash_new, keys_reg);
    assign class_zero = classify('0, keys_reg);

    always_comb
    begin
        in_value_next = in_value_reg;
        hash_next     = hash_reg;
        class_next    = class_reg;
        start_next    = start_reg;
        offset_next   = offset_reg;
        has_result    = 1'b0;
        push_entry    = '0;

        if (!in_value_reg)
        begin
            if (data_byte == CH_EQ)
            begin
                class_next    = class_cur;
                start_next    = len17;
                hash_next     = '0;
                in_value_next = 1'b1;
                has_result    = body_end;
                push_entry.first = '{cls: class_cur, vs: len17, ve: len16};
            end
            else
            begin
                hash_next  = hash_new;
                has_result = body_end;
                // tail field of an unfinished name
                push_entry.first = '{cls: class_new, vs: len17 + START_W'(1), ve: len16};
            end
        end
        else
        begin
            if (data_byte == CH_AMP)
            begin
                has_result    = 1'b1;
                in_value_next = 1'b0;
                hash_next     = '0;
                push_entry.first  = '{cls: class_reg, vs: start_reg, ve: offset_reg};
                push_entry.two    = body_end;
                push_entry.second = '{cls: class_zero, vs: len17 + START_W'(1), ve: len16};
            end
            else
            begin
                has_result = body_end;
                push_entry.first = '{cls: class_reg, vs: start_reg, ve: len16};
            end
        end

        if (body_end)
        begin
            in_value_next = 1'b0;
            hash_next     = '0;
            class_next    = CLASS_INTERFACE;
            start_next    = '0;
            offset_next   = '0;
        end
        else if (offset_reg < OFFSET_LAST)
        begin
            offset_next = len16;
        end
    end

    assign push = take && has_result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            keys_reg     <= '0;
            in_value_reg <= 1'b0;
            hash_reg     <= '0;
            class_reg    <= CLASS_INTERFACE;
            start_reg    <= '0;
            offset_reg   <= '0;
        end
        else
        begin
            keys_reg <= keys_next;
            if (take)
            begin
                in_value_reg <= in_value_next;
                hash_reg     <= hash_next;
                class_reg    <= class_next;
                start_reg    <= start_next;
                offset_reg   <= offset_next;
            end
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/ffhc_queue.sv
// short queue of result words between the front and back ends
`default_nettype none

module ffhc_queue (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    push,
    input  wire ffhc_pkg::entry_t        push_entry,
    input  wire logic                    pop,
    output ffhc_pkg::entry_t             head,
    output ffhc_pkg::queue_status_t      status
);
    import ffhc_pkg::*;

    entry_t              slots_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;

    function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    assign status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? bump(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? bump(rd_ptr_reg) : rd_ptr_reg;
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/ffhc_back.sv
// back end: splits queue words into single results behind an output register
`default_nettype none

module ffhc_back (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire ffhc_pkg::entry_t                head,
    input  wire ffhc_pkg::queue_status_t         status,
    output logic                                 pop,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic [ffhc_pkg::CLASS_W-1:0]         field_class,
    output logic [ffhc_pkg::START_W-1:0]         value_start,
    output logic [ffhc_pkg::OFFSET_W-1:0]        value_end,
    output logic                                 run_last
);
    import ffhc_pkg::*;

    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    out_last_reg, out_last_next;
    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg, pend_next;
    logic    out_free;

    assign out_free = !out_valid_reg || !result_stall;
    assign pop      = out_free && !pend_valid_reg && !status.empty;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (out_free)
        begin
            priority if (pend_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_next        = pend_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
            else if (!status.empty)
            begin
                out_valid_next  = 1'b1;
                out_next        = head.first;
                out_last_next   = !head.two;
                pend_valid_next = head.two;
                pend_next       = head.second;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
        pend_reg     <= pend_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign field_class  = out_reg.cls;
    assign value_start  = out_reg.vs;
    assign value_end    = out_reg.ve;
    assign run_last     = out_last_reg;

`ifndef SYNTH
    a_pend_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> out_valid_reg)
        else $error("second result pending without a first on the output");
    a_first_has_second: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> pend_valid_reg)
        else $error("non-final result with no second result behind it");
`endif

endmodule

`default_nettype wire

FILE: test/tb.sv
// testbench for the form field hash classifier: bursty byte stream, stalling sink, scoreboard
`timescale 1ns / 100ps

module tb;
    import ffhc_pkg::*;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASE_BYTES = 350;

    typedef struct packed {
        logic [CLASS_W-1:0]  cls;
        logic [START_W-1:0]  vs;
        logic [OFFSET_W-1:0] ve;
        logic                last;
    } field_t;

    // tracks the parse of the body and holds the fields still due from the block
    class field_tracker;
        logic [HASH_W-1:0]   iface_key = '0;
        logic [HASH_W-1:0]   method_key = '0;
        logic [HASH_W-1:0]   types_key = '0;
        logic                in_value = 1'b0;
        logic [HASH_W-1:0]   hash = '0;
        logic [CLASS_W-1:0]  cls = '0;
        logic [START_W-1:0]  start = '0;
        logic [OFFSET_W-1:0] offset = '0;
        field_t              pending[$];
        int                  errors = 0;

        task report(string msg);
            if (errors < 200)
                $display("%0t mismatch: %s", $realtime, msg);
            errors++;
        endtask

        function void set_key(logic [CFG_IDX_W-1:0] idx, logic [HASH_W-1:0] val);
            case (idx)
                REG_INTERFACE_KEY: iface_key = val;
                REG_METHOD_KEY:    method_key = val;
                REG_TYPES_KEY:     types_key = val;
                default: ;
            endcase
        endfunction

        function logic [CLASS_W-1:0] class_for(logic [HASH_W-1:0] h);
            if (h == iface_key) return CLASS_INTERFACE;
            if (h == method_key) return CLASS_METHOD;
            if (h == types_key) return CLASS_TYPES;
            return CLASS_PARAM;
        endfunction

        function void take_byte(logic [7:0] b, logic fin);
            logic [OFFSET_W-1:0] pos;
            logic [START_W-1:0]  len;
            pos = offset;
            len = {1'b0, offset} + 17'd1;
            if (!in_value) begin
                if (b == CH_EQ) begin
                    cls = class_for(hash);
                    start = len;
                    hash = '0;
                    in_value = 1'b1;
                    if (fin)
                        pending.push_back({cls, start, len[OFFSET_W-1:0], 1'b1});
                end else begin
                    hash = hash * 32'd131 + {{24{b[7]}}, b};
                    // body ended inside a name: tail field past the end
                    if (fin)
                        pending.push_back({class_for(hash), len + 17'd1,
                                           len[OFFSET_W-1:0], 1'b1});
                end
            end else if (b == CH_AMP) begin
                pending.push_back({cls, start, pos, !fin});
                in_value = 1'b0;
                hash = '0;
                if (fin)
                    pending.push_back({class_for('0), len + 17'd1,
                                       len[OFFSET_W-1:0], 1'b1});
            end else if (fin) begin
                pending.push_back({cls, start, len[OFFSET_W-1:0], 1'b1});
            end

            if (fin) begin
                in_value = 1'b0;
                hash = '0;
                cls = '0;
                start = '0;
                offset = '0;
            end else if (offset < OFFSET_LAST) begin
                offset = offset + 1'b1;
            end
        endfunction

        task check_field(field_t got);
            field_t want;
            if (pending.size() == 0) begin
                report($sformatf("unexpected word class %0d start %0d end %0d last %0d",
                                 got.cls, got.vs, got.ve, got.last));
                return;
            end
            want = pending.pop_front();
            if (got.cls !== want.cls)
                report($sformatf("field_class %0d, want %0d", got.cls, want.cls));
            if (got.vs !== want.vs)
                report($sformatf("value_start %0d, want %0d", got.vs, want.vs));
            if (got.ve !== want.ve)
                report($sformatf("value_end %0d, want %0d", got.ve, want.ve));
            if (got.last !== want.last)
                report($sformatf("run_last %0d, want %0d", got.last, want.last));
        endtask
    endclass

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [HASH_W-1:0]    cfg_data = '0;
    logic                 byte_valid = 1'b0;
    logic                 byte_stall;
    logic [7:0]           data_byte = '0;
    logic                 body_end = 1'b0;
    logic                 result_valid;
    logic                 result_stall = 1'b0;
    logic [CLASS_W-1:0]   field_class;
    logic [START_W-1:0]   value_start;
    logic [OFFSET_W-1:0]  value_end;
    logic                 run_last;
    field_t               seen_field;

    field_tracker board = new();

    logic [7:0] body_bytes[$];
    logic [7:0] key_name[3][3];
    int         key_len[3];
    int         burst_left = 0;
    int         cycle_no = 0;
    int         hold_left = 0;
    int         stall_mode = 0;

    form_field_hash_classifier uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .data_byte    (data_byte),
        .body_end     (body_end),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .field_class  (field_class),
        .value_start  (value_start),
        .value_end    (value_end),
        .run_last     (run_last)
    );

    always #6 clk = ~clk;

    assign seen_field = {field_class, value_start, value_end, run_last};

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            board.check_field(seen_field);
    end

    // sink: the stall pattern is drawn anew now and then, with a long hold at times
    always @(negedge clk)
    begin
        cycle_no++;
        if (hold_left > 0) begin
            hold_left--;
            result_stall <= 1'b1;
        end else begin
            if (cycle_no % 1500 == 700)
                hold_left = 90;
            if (cycle_no % 300 == 0)
                stall_mode = $urandom_range(0, 3);
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 9) < 3);
                2: result_stall <= ((cycle_no % 4) >= 2);
                default: result_stall <= ($urandom_range(0, 9) < 7);
            endcase
        end
    end

    initial
    begin
        #12_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [7:0] any_byte_but(logic [7:0] x);
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255)); while (b == x);
        return b;
    endfunction

    function automatic logic [HASH_W-1:0] hash_of_key(int k);
        logic [HASH_W-1:0] h;
        h = '0;
        for (int i = 0; i < key_len[k]; i++)
            h = h * 32'd131 + {{24{key_name[k][i][7]}}, key_name[k][i]};
        return h;
    endfunction

    function automatic void push_key_name(int k);
        for (int i = 0; i < key_len[k]; i++)
            body_bytes.push_back(key_name[k][i]);
    endfunction

    function automatic void push_random_name();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) body_bytes.push_back(any_byte_but(CH_EQ));
    endfunction

    // name=value pairs, mostly with key names, ending after a value, after a '&' or inside a trailing name
    function automatic void fill_well_formed();
        int fields;
        int pick;
        int vlen;
        body_bytes = {};
        fields = $urandom_range(1, 4);
        for (int f = 0; f < fields; f++) begin
            if (f > 0)
                body_bytes.push_back(CH_AMP);
            pick = $urandom_range(0, 9);
            if (pick < 6)
                push_key_name(pick % 3);
            else if (pick < 9)
                push_random_name();
            body_bytes.push_back(CH_EQ);
            vlen = $urandom_range(0, 5);
            repeat (vlen) body_bytes.push_back(any_byte_but(CH_AMP));
        end
        case ($urandom_range(0, 5))
            0: body_bytes.push_back(CH_AMP);
            1: begin
                body_bytes.push_back(CH_AMP);
                push_random_name();
            end
            default: ;
        endcase
    endfunction

    function automatic void fill_noise();
        int n;
        int pick;
        body_bytes = {};
        n = $urandom_range(1, 12);
        repeat (n) begin
            pick = $urandom_range(0, 9);
            if (pick < 3)
                body_bytes.push_back(CH_EQ);
            else if (pick < 5)
                body_bytes.push_back(CH_AMP);
            else
                body_bytes.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    // one body byte per call; entered and left at a falling edge
    task automatic send_byte(logic [7:0] b, logic fin);
        int gap;
        byte_valid <= 1'b1;
        data_byte <= b;
        body_end <= fin;
        do @(posedge clk); while (byte_stall);
        board.take_byte(b, fin);
        @(negedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap = $urandom_range(0, 6);
            if (gap > 0) begin
                byte_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    endtask

    task automatic send_body();
        foreach (body_bytes[i])
            send_byte(body_bytes[i], i == body_bytes.size() - 1);
    endtask

    task automatic write_key(logic [CFG_IDX_W-1:0] idx, logic [HASH_W-1:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        board.set_key(idx, val);
        @(negedge clk);
    endtask

    // wait out every pending field, then let the words that give none drain
    task automatic settle();
        int waited;
        byte_valid <= 1'b0;
        waited = 0;
        while (board.pending.size() != 0 && waited < 5000) begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
        if (board.pending.size() != 0) begin
            board.report($sformatf("%0d fields never came out", board.pending.size()));
            board.pending = {};
        end
    endtask

    task automatic set_phase(int p);
        logic [HASH_W-1:0] kv[3];
        for (int k = 0; k < 3; k++) begin
            key_len[k] = $urandom_range(1, 3);
            for (int i = 0; i < 3; i++)
                key_name[k][i] = any_byte_but(CH_EQ);
        end
        case (p)
            1: begin
                // equal keys: the interface key must win
                key_len[1] = key_len[0];
                key_name[1] = key_name[0];
            end
            2: begin
                // a lone 0xff hashes to all ones; an empty name hashes to zero
                key_len[0] = 1;
                key_name[0][0] = 8'hFF;
                key_len[1] = 0;
            end
            3: key_len = '{0, 0, 0};
            default: ;
        endcase
        for (int k = 0; k < 3; k++)
            kv[k] = hash_of_key(k);
        if (p == 4)
            kv[0] = $urandom;
        write_key(REG_INTERFACE_KEY, kv[0]);
        write_key(REG_METHOD_KEY, kv[1]);
        write_key(REG_TYPES_KEY, kv[2]);
        if (p == 4)
            write_key(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        int sent;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset keys are all zero, so an empty name is an interface field
        body_bytes = '{CH_EQ};
        send_body();
        body_bytes = '{CH_AMP, 8'hFF, CH_EQ, 8'h80, CH_EQ, CH_AMP};
        send_body();
        body_bytes = '{8'h00, 8'h7F};
        send_body();
        body_bytes = '{8'h6B, CH_EQ, CH_AMP, 8'h6D};
        send_body();

        for (int p = 0; p < 5; p++) begin
            settle();
            set_phase(p);
            if (p == 0) begin
                body_bytes = {};
                for (int k = 0; k < 3; k++) begin
                    push_key_name(k);
                    body_bytes.push_back(CH_EQ);
                    body_bytes.push_back(k == 2 ? 8'h76 : CH_AMP);
                end
                send_body();
            end
            sent = 0;
            while (sent < PHASE_BYTES) begin
                if ($urandom_range(0, 99) < 85)
                    fill_well_formed();
                else
                    fill_noise();
                send_body();
                sent += body_bytes.size();
            end
        end

        settle();
        if (board.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
